@@ rtl/core/cdsw_pkg.sv @@
package cdsw_pkg;

	localparam int FUNC_W  = 3;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int WDAY_W  = 3;
	localparam int Q100_W  = 8;
	localparam int YP_W    = 15;
	localparam int SUM_W   = 15;
	localparam int CFG_AW  = 1;

	// Division by 100 as a multiply by a scaled reciprocal; exact below 43690.
	localparam int               RECIP_SH  = 20;
	localparam logic [YEAR_W-1:0] RECIP_100 = 14'd10486;

	// Keeps the weekday sum positive (a multiple of 7 above the largest
	// century count) and folds in the final shift to Sunday-based numbering.
	localparam logic [SUM_W-1:0] WDAY_BIAS = 15'd169;

	localparam logic [FUNC_W-1:0] FN_NONE       = 3'd0;
	localparam logic [FUNC_W-1:0] FN_NEXT_DAY   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PREV_DAY   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_NEXT_MONTH = 3'd3;
	localparam logic [FUNC_W-1:0] FN_PREV_MONTH = 3'd4;
	localparam logic [FUNC_W-1:0] FN_NEXT_YEAR  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_PREV_YEAR  = 3'd6;

	localparam logic [CFG_AW-1:0] CFG_YEAR_LO = 1'd0;
	localparam logic [CFG_AW-1:0] CFG_YEAR_HI = 1'd1;

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               in_ok;
		logic               wrap;
	} date_res_t;

	function automatic logic [Q100_W-1:0] div100(input logic [YP_W-1:0] x);
		logic [YP_W+YEAR_W-1:0] p;
		p = {{YEAR_W{1'b0}}, x} * {{YP_W{1'b0}}, RECIP_100};
		return p[RECIP_SH+Q100_W-1:RECIP_SH];
	endfunction

	// y is a leap year; q must be y / 100.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic [Q100_W-1:0] q);
		logic [YP_W-1:0] hund;
		logic            rem0;
		hund = {7'd0, q} * 15'd100;
		rem0 = ({1'b0, y} == hund);
		return (y[1:0] == 2'b00) && (!rem0 || (q[1:0] == 2'b00));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	// 2m + 3(m+1)/5 modulo 7, with January and February counted as months 13 and 14.
	function automatic logic [WDAY_W-1:0] month_term(input logic [MONTH_W-1:0] m);
		logic [WDAY_W-1:0] t;
		case (m)
			4'd0:    t = 3'd0;
			4'd1:    t = 3'd6;
			4'd2:    t = 3'd2;
			4'd3:    t = 3'd1;
			4'd4:    t = 3'd4;
			4'd5:    t = 3'd6;
			4'd6:    t = 3'd2;
			4'd7:    t = 3'd4;
			4'd8:    t = 3'd0;
			4'd9:    t = 3'd3;
			4'd10:   t = 3'd5;
			4'd11:   t = 3'd1;
			4'd12:   t = 3'd3;
			4'd13:   t = 3'd6;
			4'd14:   t = 3'd2;
			default: t = 3'd4;
		endcase
		return t;
	endfunction

	// Since 8 is 1 modulo 7, summing the octal digits keeps the residue.
	function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] s);
		logic [5:0] a;
		logic [3:0] b;
		logic [3:0] c;
		a = {3'd0, s[2:0]} + {3'd0, s[5:3]} + {3'd0, s[8:6]} + {3'd0, s[11:9]}
			+ {3'd0, s[14:12]};
		b = {1'b0, a[5:3]} + {1'b0, a[2:0]};
		c = {3'd0, b[3]} + {1'b0, b[2:0]};
		if (c >= 4'd7) begin
			c = c - 4'd7;
		end
		return c[2:0];
	endfunction

endpackage

@@ rtl/core/cdsw_step.sv @@
module cdsw_step
	import cdsw_pkg::*;
(
	input  logic [FUNC_W-1:0]  func,
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	input  logic [Q100_W-1:0]  year_q100,
	input  logic [YEAR_W-1:0]  year_lo,
	input  logic [YEAR_W-1:0]  year_hi,
	output date_res_t          res
);

	logic               leap;
	logic [DAY_W-1:0]   len;
	logic               in_ok;
	logic [YEAR_W-1:0]  year_inc;
	logic [YEAR_W-1:0]  year_dec;
	logic               inc_wrap;
	logic               dec_wrap;
	logic [MONTH_W-1:0] month_inc;
	logic [MONTH_W-1:0] month_dec;

	assign leap      = is_leap(year, year_q100);
	assign len       = month_len(month, leap);
	assign in_ok     = (year >= year_lo) && (year <= year_hi) && (len != '0)
		&& (day != '0) && (day <= len);
	assign year_inc  = year + 14'd1;
	assign year_dec  = year - 14'd1;
	assign inc_wrap  = &year;
	assign dec_wrap  = (year == '0);
	assign month_inc = month + 4'd1;
	assign month_dec = month - 4'd1;

	always_comb begin
		res.year  = year;
		res.month = month;
		res.day   = day;
		res.in_ok = in_ok;
		res.wrap  = 1'b0;
		if (in_ok) begin
			case (func)
				FN_NEXT_DAY: begin
					if (day == len) begin
						res.day = 5'd1;
						if (month == MON_DEC) begin
							res.month = MON_JAN;
							res.year  = year_inc;
							res.wrap  = inc_wrap;
						end else begin
							res.month = month_inc;
						end
					end else begin
						res.day = day + 5'd1;
					end
				end
				FN_PREV_DAY: begin
					if (day == 5'd1) begin
						if (month == MON_JAN) begin
							res.month = MON_DEC;
							res.year  = year_dec;
							res.wrap  = dec_wrap;
							res.day   = 5'd31;
						end else begin
							res.month = month_dec;
							res.day   = month_len(month_dec, leap);
						end
					end else begin
						res.day = day - 5'd1;
					end
				end
				FN_NEXT_MONTH: begin
					if (month == MON_DEC) begin
						res.month = MON_JAN;
						res.year  = year_inc;
						res.wrap  = inc_wrap;
					end else begin
						res.month = month_inc;
					end
				end
				FN_PREV_MONTH: begin
					if (month == MON_JAN) begin
						res.month = MON_DEC;
						res.year  = year_dec;
						res.wrap  = dec_wrap;
					end else begin
						res.month = month_dec;
					end
				end
				FN_NEXT_YEAR: begin
					res.year = year_inc;
					res.wrap = inc_wrap;
				end
				FN_PREV_YEAR: begin
					res.year = year_dec;
					res.wrap = dec_wrap;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/core/calendar_date_step_weekday.sv @@
// Throughput: one request per cycle while the master side keeps taking results, through
// six register ranks.
// Every rank has its own valid bit and moves on when the rank after it is empty or
// moving, so bubbles are squeezed out while the output waits.
// Reset (arst_n low) empties the pipeline and sets the year limits to 1 and 9999.
module calendar_date_step_weekday
	import cdsw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// func[2:0], year_in[16:3], month_in[20:17], day_in[25:21], zero[31:26]
	input  logic [31:0]       s_axis_tdata,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// year_out[13:0], month_out[17:14], day_out[22:18], weekday[25:23],
	// leap_year[26], date_valid[27], zero[31:28]
	output logic [31:0]       m_axis_tdata,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [YEAR_W-1:0] cfg_wdata
);

	// Year limits. The user must change them only while the pipeline is empty; the block does not enforce it.
	logic [YEAR_W-1:0] year_lo_q;
	logic [YEAR_W-1:0] year_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_lo_q <= 14'd1;
			year_hi_q <= 14'd9999;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_YEAR_LO: year_lo_q <= cfg_wdata;
				CFG_YEAR_HI: year_hi_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Pipeline flow control: a rank loads when it is empty or its contents leave.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, out_vld_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_out;

	assign rdy_out       = !out_vld_q || m_axis_tready;
	assign rdy_s5        = !vld_s5 || rdy_out;
	assign rdy_s4        = !vld_s4 || rdy_s5;
	assign rdy_s3        = !vld_s3 || rdy_s4;
	assign rdy_s2        = !vld_s2 || rdy_s3;
	assign rdy_s1        = !vld_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;
	assign m_axis_tvalid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
			if (rdy_out) begin
				out_vld_q <= vld_s5;
			end
		end
	end

	// Rank 1: the request as it arrived.
	logic [FUNC_W-1:0]  func_s1;
	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			func_s1  <= s_axis_tdata[2:0];
			year_s1  <= s_axis_tdata[16:3];
			month_s1 <= s_axis_tdata[20:17];
			day_s1   <= s_axis_tdata[25:21];
		end
	end

	// Rank 2: the input year's century count, needed for its leap flag.
	logic [FUNC_W-1:0]  func_s2;
	logic [YEAR_W-1:0]  year_s2;
	logic [MONTH_W-1:0] month_s2;
	logic [DAY_W-1:0]   day_s2;
	logic [Q100_W-1:0]  qin_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			func_s2  <= func_s1;
			year_s2  <= year_s1;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
			qin_s2   <= div100({1'b0, year_s1});
		end
	end

	// Rank 3: the stepped date. An invalid input date passes through unchanged.
	date_res_t step_res;
	date_res_t res_s3;

	cdsw_step u_step (
		.func      (func_s2),
		.year      (year_s2),
		.month     (month_s2),
		.day       (day_s2),
		.year_q100 (qin_s2),
		.year_lo   (year_lo_q),
		.year_hi   (year_hi_q),
		.res       (step_res)
	);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			res_s3 <= step_res;
		end
	end

	// Rank 4: century counts of the result year and of the shifted weekday year.
	// January and February belong to the year before; the extra 400 years keep the
	// shifted year positive without changing the weekday.
	logic [YP_W-1:0]   yp_nx;
	date_res_t         res_s4;
	logic [YP_W-1:0]   yp_s4;
	logic [Q100_W-1:0] qo_s4;
	logic [Q100_W-1:0] qyp_s4;

	assign yp_nx = {1'b0, res_s3.year}
		+ (((res_s3.month == MON_JAN) || (res_s3.month == MON_FEB)) ? 15'd399 : 15'd400);

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			res_s4 <= res_s3;
			yp_s4  <= yp_nx;
			qo_s4  <= div100({1'b0, res_s3.year});
			qyp_s4 <= div100(yp_nx);
		end
	end

	// Rank 5: leap flag, validity and the weekday sum before its reduction.
	logic              leap_nx;
	logic              ok_nx;
	logic [SUM_W-1:0]  sum_nx;
	date_res_t         res_s5;
	logic              leap_s5;
	logic              ok_s5;
	logic [SUM_W-1:0]  sum_s5;

	assign leap_nx = is_leap(res_s4.year, qo_s4);
	assign ok_nx   = res_s4.in_ok && !res_s4.wrap
		&& (res_s4.year >= year_lo_q) && (res_s4.year <= year_hi_q)
		&& (res_s4.day != '0) && (res_s4.day <= month_len(res_s4.month, leap_nx));
	assign sum_nx  = {10'd0, res_s4.day} + {12'd0, month_term(res_s4.month)} + yp_s4
		+ {2'd0, yp_s4[YP_W-1:2]} + {9'd0, qyp_s4[Q100_W-1:2]} + WDAY_BIAS
		- {7'd0, qyp_s4};

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			res_s5  <= res_s4;
			leap_s5 <= leap_nx;
			ok_s5   <= ok_nx;
			sum_s5  <= sum_nx;
		end
	end

	// Output register: weekday reduced modulo 7, the rest carried.
	logic [YEAR_W-1:0]  year_out_q;
	logic [MONTH_W-1:0] month_out_q;
	logic [DAY_W-1:0]   day_out_q;
	logic [WDAY_W-1:0]  weekday_q;
	logic               leap_q;
	logic               valid_q;

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			year_out_q  <= res_s5.year;
			month_out_q <= res_s5.month;
			day_out_q   <= res_s5.day;
			weekday_q   <= mod7(sum_s5);
			leap_q      <= leap_s5;
			valid_q     <= ok_s5;
		end
	end

	assign m_axis_tdata = {4'd0, valid_q, leap_q, weekday_q, day_out_q, month_out_q,
		year_out_q};

	// A valid result always names a real day of a real month.
	a_valid_date: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && valid_q) |-> ((day_out_q != '0) && (month_out_q >= MON_JAN)
			&& (month_out_q <= MON_DEC)))
		else $error("valid result with an impossible day or month");

	// February of a valid result never goes past the 29th, and the 29th only in leap years.
	a_feb_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && valid_q && (month_out_q == MON_FEB))
			|-> ((day_out_q <= 5'd28) || ((day_out_q == 5'd29) && leap_q)))
		else $error("valid February result beyond its length");

	// The weekday reduction never leaves 0..6.
	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (weekday_q <= 3'd6))
		else $error("weekday out of range");

	// A leap year is always a multiple of four.
	a_leap_mod4: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && leap_q) |-> (year_out_q[1:0] == 2'b00))
		else $error("leap flag on a year that is not a multiple of four");

	// An accepted request always lands in the first rank.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_s1)
		else $error("accepted request lost at the first rank");

endmodule
